// ===== src/deq_pkg.sv =====
// Shared types, constants and codes for the double-ended queue.
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_REAR  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_REAR   = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        cmd_code_t          command;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic               is_empty;
        logic               is_full;
    } result_t;

    // Access to the entry memory for one transaction.
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } mem_req_t;

    // Registered result control, aligned with the memory read data.
    typedef struct packed {
        logic    valid;
        status_t status;
        logic    pop_ok;
        logic    is_empty;
        logic    is_full;
    } res_ctrl_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

endpackage

// ===== src/deq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module deq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4,
    parameter int DEPTH  = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/deq_ctrl.sv =====
// Front/rear positions, occupancy count and memory access control.
module deq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  deq_pkg::cmd_t      cmd,
    output deq_pkg::mem_req_t  mem_req,
    output deq_pkg::res_ctrl_t res_ctrl
);

    logic [deq_pkg::PTR_W-1:0] front_reg, front_next;
    logic [deq_pkg::PTR_W-1:0] rear_reg,  rear_next;
    logic [deq_pkg::CNT_W-1:0] count_reg, count_next;
    deq_pkg::res_ctrl_t        res_reg,   res_next;

    logic is_full_now;
    logic is_empty_now;

    assign is_full_now  = (count_reg == deq_pkg::CNT_FULL);
    assign is_empty_now = (count_reg == '0);

    always_comb
    begin
        front_next       = front_reg;
        rear_next        = rear_reg;
        count_next       = count_reg;
        mem_req.we       = 1'b0;
        mem_req.waddr    = rear_reg;
        mem_req.wdata    = cmd.value;
        mem_req.re       = 1'b0;
        mem_req.raddr    = front_reg;
        res_next.valid   = accept;
        res_next.status  = deq_pkg::ST_OK;
        res_next.pop_ok  = 1'b0;

        unique case (cmd.command)
            deq_pkg::CMD_PUSH_FRONT:
            begin
                if (is_full_now)
                begin
                    res_next.status = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    front_next    = deq_pkg::ptr_dec(front_reg);
                    mem_req.we    = accept;
                    mem_req.waddr = front_next;
                    count_next    = count_reg + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::CMD_PUSH_REAR:
            begin
                if (is_full_now)
                begin
                    res_next.status = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    mem_req.we    = accept;
                    mem_req.waddr = rear_reg;
                    rear_next     = deq_pkg::ptr_inc(rear_reg);
                    count_next    = count_reg + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::CMD_POP_FRONT:
            begin
                if (is_empty_now)
                begin
                    res_next.status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    mem_req.re      = accept;
                    mem_req.raddr   = front_reg;
                    front_next      = deq_pkg::ptr_inc(front_reg);
                    count_next      = count_reg - deq_pkg::CNT_W'(1);
                    res_next.pop_ok = 1'b1;
                end
            end
            deq_pkg::CMD_POP_REAR:
            begin
                if (is_empty_now)
                begin
                    res_next.status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    rear_next       = deq_pkg::ptr_dec(rear_reg);
                    mem_req.re      = accept;
                    mem_req.raddr   = rear_next;
                    count_next      = count_reg - deq_pkg::CNT_W'(1);
                    res_next.pop_ok = 1'b1;
                end
            end
            default:
            begin
                res_next.status = deq_pkg::ST_OK;
            end
        endcase

        res_next.is_empty = (count_next == '0);
        res_next.is_full  = (count_next == deq_pkg::CNT_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                count_reg <= count_next;
                res_reg   <= res_next;
            end
            else
            begin
                res_reg.valid <= 1'b0;
            end
        end
    end

    assign res_ctrl = res_reg;

endmodule

// ===== src/double_ended_queue.sv =====
// Double-ended queue top level: command port, control and entry memory.
// Results: the result of a transaction accepted at a clock edge is shown on the
//   cycle after that edge, with done high for exactly one cycle.
// Throughput: one transaction per cycle; busy stays low, since each transaction
//   makes at most one access to the single-port-per-direction entry memory.
// Reset: rst_n clears positions, occupancy and done; memory contents are not cleared.
module double_ended_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  deq_pkg::cmd_t    cmd,
    output logic             done,
    output deq_pkg::result_t result
);

    deq_pkg::mem_req_t  mem_req;
    deq_pkg::res_ctrl_t res_ctrl;
    logic [deq_pkg::DATA_W-1:0] rd_data;
    logic accept;

    // Commands are never held off: pointer updates finish in the accept cycle.
    // A pop right after a push to the same entry reads the array after the write
    // edge, so no forwarding path is needed.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .mem_req  (mem_req),
        .res_ctrl (res_ctrl)
    );

    deq_ram #(
        .DATA_W (deq_pkg::DATA_W),
        .ADDR_W (deq_pkg::PTR_W),
        .DEPTH  (deq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    // Drive the popped value only for a successful pop; zero otherwise.
    assign done                = res_ctrl.valid;
    assign result.popped_value = res_ctrl.pop_ok ? $signed(rd_data) : 32'sd0;
    assign result.status       = res_ctrl.status;
    assign result.is_empty     = res_ctrl.is_empty;
    assign result.is_full      = res_ctrl.is_full;

    // Every accepted transaction yields exactly one result on the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("done missing after accepted transaction");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("done without accepted transaction");

    a_empty_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.is_empty && result.is_full))
        else $error("queue reported both empty and full");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != deq_pkg::ST_OK) |-> (result.popped_value == 32'sd0))
        else $error("refused transaction returned a nonzero value");

    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.command == deq_pkg::CMD_PUSH_FRONT
                    || cmd.command == deq_pkg::CMD_PUSH_REAR)) |=> !result.is_empty)
        else $error("queue empty after push");

endmodule
